[hdl/ufs_pkg.sv]
// ============================================================================
// ufs_pkg
// Shared types and constants of the UTF-8 filename sanitizer: the job record
// that travels from the front end to the output stage, and byte constants.
// ============================================================================
`default_nettype none

package ufs_pkg;

    // Masks for recognizing UTF-8 continuation bytes (10xxxxxx).
    localparam logic [7:0] CONT_MASK   = 8'hC0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LIMIT_RESET = 8'd120;
    localparam logic [7:0] UNDERSCORE  = 8'h5F;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    // One accepted title byte, reduced to the bytes it releases.
    typedef struct packed {
        logic [3:0][7:0] bytes;     // codepoint bytes, first in bytes[0]
        logic [2:0]      nbytes;    // number of codepoint bytes, 0 to 4
        logic            uscore;    // an underscore goes before the bytes
        logic            untitled;  // emit the fallback stem
        logic            stem_end;  // last request of the stem
    } job_t;

    // Number of bytes announced by a UTF-8 lead byte, 0 if not a lead byte.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        len = 3'd0;
        if ((b & 8'hE0) == 8'hC0) len = 3'd2;
        else if ((b & 8'hF0) == 8'hE0) len = 3'd3;
        else if ((b & 8'hF8) == 8'hF0) len = 3'd4;
        return len;
    endfunction

    // Bytes of the fallback stem "untitled".
    function automatic logic [7:0] fallback_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h75; // u
            3'd1:    c = 8'h6E; // n
            3'd2:    c = 8'h74; // t
            3'd3:    c = 8'h69; // i
            3'd4:    c = 8'h74; // t
            3'd5:    c = 8'h6C; // l
            3'd6:    c = 8'h65; // e
            3'd7:    c = 8'h64; // d
            default: c = 8'h64;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

[hdl/ufs_front.sv]
// ============================================================================
// ufs_front
// Front end: accepts title bytes, collects UTF-8 sequences, applies the stem
// limit and turns each accepted item into at most one job for the queue.
// ============================================================================
`default_nettype none

module ufs_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic [7:0]    limit,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    in_byte,
    input  wire logic          byte_present,
    input  wire logic          title_end,
    input  wire logic          q_full,
    output logic               push,
    output ufs_pkg::job_t      job
);

    logic [2:0][7:0] seq_buf_reg, seq_buf_next;
    logic [2:0]      seq_exp_reg, seq_exp_next;
    logic [1:0]      seq_held_reg, seq_held_next;
    logic            us_pend_reg, us_pend_next;
    logic            any_reg, any_next;
    logic [7:0]      count_reg, count_next;
    logic            cut_reg, cut_next;

    logic            accept;
    logic [7:0]      lc;
    logic            is_cont;
    logic [3:0][7:0] cp;
    logic [2:0]      keep_len;
    logic [2:0]      lead_len;
    logic [8:0]      cnt_a;
    logic [8:0]      limit9;
    logic            uscore;
    logic [2:0]      nbytes;

    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;
    assign is_cont  = (in_byte & ufs_pkg::CONT_MASK) == ufs_pkg::CONT_TAG;
    assign lead_len = ufs_pkg::lead_length(in_byte);
    assign limit9   = {1'b0, limit};

    always_comb
    begin
        lc = in_byte;
        if (in_byte >= 8'h41 && in_byte <= 8'h5A) lc = in_byte + ufs_pkg::CASE_OFFSET;
    end

    always_comb
    begin
        seq_buf_next  = seq_buf_reg;
        seq_exp_next  = seq_exp_reg;
        seq_held_next = seq_held_reg;
        us_pend_next  = us_pend_reg;
        any_next      = any_reg;
        count_next    = count_reg;
        cut_next      = cut_reg;
        cp            = '0;
        keep_len      = 3'd0;
        uscore        = 1'b0;
        nbytes        = 3'd0;
        cnt_a         = {1'b0, count_reg};

        if (byte_present)
        begin
            if (seq_exp_reg != 3'd0 && is_cont)
            begin
                if ({1'b0, seq_held_reg} + 3'd1 >= seq_exp_reg)
                begin
                    // Sequence complete: held bytes followed by this one.
                    for (int k = 0; k < 3; k++)
                    begin
                        if (2'(k) < seq_held_reg) cp[k] = seq_buf_reg[k];
                        else if (2'(k) == seq_held_reg) cp[k] = in_byte;
                    end
                    if (seq_held_reg == 2'd3) cp[3] = in_byte;
                    keep_len      = {1'b0, seq_held_reg} + 3'd1;
                    seq_exp_next  = 3'd0;
                    seq_held_next = 2'd0;
                end
                else
                begin
                    seq_buf_next[seq_held_reg] = in_byte;
                    seq_held_next              = seq_held_reg + 2'd1;
                end
            end
            else
            begin
                // A broken sequence is dropped and this byte starts afresh.
                seq_exp_next  = 3'd0;
                seq_held_next = 2'd0;
                if (!in_byte[7])
                begin
                    if ((lc >= 8'h61 && lc <= 8'h7A) || (lc >= 8'h30 && lc <= 8'h39))
                    begin
                        cp[0]    = lc;
                        keep_len = 3'd1;
                    end
                    else if (lc == ufs_pkg::CHAR_SPACE || lc == ufs_pkg::CHAR_DASH ||
                             lc == ufs_pkg::UNDERSCORE)
                    begin
                        if (any_reg) us_pend_next = 1'b1;
                    end
                end
                else if (lead_len != 3'd0)
                begin
                    seq_buf_next[0] = in_byte;
                    seq_held_next   = 2'd1;
                    seq_exp_next    = lead_len;
                end
            end
        end

        if (keep_len != 3'd0)
        begin
            any_next     = 1'b1;
            us_pend_next = 1'b0;
            if (!cut_reg && us_pend_reg)
            begin
                if (cnt_a + 9'd1 <= limit9)
                begin
                    uscore = 1'b1;
                    cnt_a  = cnt_a + 9'd1;
                end
                else
                begin
                    cut_next = 1'b1;
                end
            end
            if (!cut_next)
            begin
                if (cnt_a + {6'd0, keep_len} <= limit9)
                begin
                    nbytes = keep_len;
                    cnt_a  = cnt_a + {6'd0, keep_len};
                end
                else
                begin
                    cut_next = 1'b1;
                end
            end
            count_next = cnt_a[7:0];
        end

        job.bytes    = cp;
        job.nbytes   = nbytes;
        job.uscore   = uscore;
        job.stem_end = title_end;
        job.untitled = title_end && (count_next == 8'd0);

        if (title_end)
        begin
            seq_exp_next  = 3'd0;
            seq_held_next = 2'd0;
            us_pend_next  = 1'b0;
            any_next      = 1'b0;
            count_next    = 8'd0;
            cut_next      = 1'b0;
        end
    end

    assign push = accept && (nbytes != 3'd0 || uscore || title_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_exp_reg  <= 3'd0;
            seq_held_reg <= 2'd0;
            us_pend_reg  <= 1'b0;
            any_reg      <= 1'b0;
            count_reg    <= 8'd0;
            cut_reg      <= 1'b0;
        end
        else if (accept)
        begin
            seq_exp_reg  <= seq_exp_next;
            seq_held_reg <= seq_held_next;
            us_pend_reg  <= us_pend_next;
            any_reg      <= any_next;
            count_reg    <= count_next;
            cut_reg      <= cut_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) seq_buf_reg <= seq_buf_next;
    end

    // A sequence in progress always holds fewer bytes than it announced.
    a_held_below_expected: assert property (@(posedge clk) disable iff (!rst_n)
        seq_exp_reg != 3'd0 |-> {1'b0, seq_held_reg} < seq_exp_reg)
        else $error("held byte count reached the expected length");

    // The end of a title returns the title state to its reset value.
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && title_end |=> count_reg == 8'd0 && !cut_reg && !any_reg &&
                                seq_exp_reg == 3'd0)
        else $error("title state not cleared after end of title");

endmodule

`default_nettype wire

[hdl/ufs_queue.sv]
// ============================================================================
// ufs_queue
// Short job queue between the front end and the output stage.
// ============================================================================
`default_nettype none

module ufs_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire ufs_pkg::job_t wdata,
    output logic               full,
    input  wire logic          pop,
    output ufs_pkg::job_t      rdata,
    output logic               not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ufs_pkg::job_t  slot_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    assign full      = cnt_reg == CW'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign rdata     = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop) cnt_next = cnt_reg + CW'(1);
        else if (pop && !push) cnt_next = cnt_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) slot_reg[wr_ptr_reg] <= wdata;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("job popped from an empty queue");

endmodule

`default_nettype wire

[hdl/ufs_back.sv]
// ============================================================================
// ufs_back
// Output stage: walks the head job one byte per cycle, while out_stall is
// low, into the output register and retires the job with its last byte.
// ============================================================================
`default_nettype none

module ufs_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ufs_pkg::job_t head,
    input  wire logic          head_valid,
    output logic               pop,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [7:0]         out_byte,
    output logic               out_present,
    output logic               stem_end
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       present_reg;
    logic       end_reg;

    logic       load;
    logic       take;
    logic       last;
    logic [3:0] total;
    logic [2:0] idx_m1;
    logic [7:0] sel_byte;

    assign load  = !valid_reg || !out_stall;
    assign take  = head_valid && load;
    assign total = head.untitled ? 4'd8 : {3'd0, head.uscore} + {1'b0, head.nbytes};
    assign last  = (total == 4'd0) || ({1'b0, idx_reg} + 4'd1 == total);
    assign pop   = take && last;
    assign idx_m1 = idx_reg - 3'd1;

    always_comb
    begin
        if (head.untitled) sel_byte = ufs_pkg::fallback_char(idx_reg);
        else if (head.uscore && idx_reg == 3'd0) sel_byte = ufs_pkg::UNDERSCORE;
        else if (head.uscore) sel_byte = head.bytes[idx_m1[1:0]];
        else sel_byte = head.bytes[idx_reg[1:0]];
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (take) idx_next = last ? 3'd0 : idx_reg + 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 3'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load) valid_reg <= head_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg    <= (total == 4'd0) ? 8'd0 : sel_byte;
            present_reg <= total != 4'd0;
            end_reg     <= head.stem_end && last;
        end
    end

    assign out_valid   = valid_reg;
    assign out_byte    = byte_reg;
    assign out_present = present_reg;
    assign stem_end    = end_reg;

    // A job partly sent stays at the head of the queue until its last byte.
    a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg != 3'd0 |-> head_valid)
        else $error("job left the queue before all of its bytes were sent");

    // A bare end marker carries no byte and always closes the stem.
    a_marker_closes: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !present_reg |-> end_reg)
        else $error("byte-less request that does not end the stem");

endmodule

`default_nettype wire

[hdl/utf8_filename_sanitizer_core.sv]
// ============================================================================
// utf8_filename_sanitizer_core
// Turns a title, fed one byte per request, into a filename stem: lowercase
// ASCII letters, digits, single underscores and whole UTF-8 codepoints, cut
// on a codepoint boundary at the programmed stem limit, "untitled" if empty.
// ============================================================================
//
//   Channel   Direction  Handshake              Payload
//   --------  ---------  ---------------------  ---------------------------------
//   in        sink       in_valid / in_stall    in_byte, byte_present, title_end
//   out       source     out_valid / out_stall  out_byte, out_present, stem_end
//   cfg       sink       cfg_valid / cfg_ready  stem_limit
//
// The front end takes one input request per cycle while the job queue has
// room. Each request releases 0 to 5 stem bytes (8 for the fallback stem, one
// bare marker for an empty end); the output stage sends one per cycle while
// out_stall is low. The first result of an item passes through the job queue
// and then the output register before it is offered.
// Reset is asynchronous and active low; the stem limit returns to 120 and no
// clearing pass is needed. Output stalls fill the queue and then raise
// in_stall; the output register and the queue keep both sides busy otherwise.
// ============================================================================
`default_nettype none

module utf8_filename_sanitizer_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire logic       byte_present,
    input  wire logic       title_end,

    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      out_byte,
    output logic            out_present,
    output logic            stem_end,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] stem_limit
);

    // Stem limit register. The user must issue writes only while the block is idle;
    // the block itself does not enforce this, since cfg_ready is held high.
    logic [7:0] limit_reg;

    ufs_pkg::job_t push_job;
    ufs_pkg::job_t head_job;
    logic          push;
    logic          q_full;
    logic          head_valid;
    logic          pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= ufs_pkg::LIMIT_RESET;
        else if (cfg_valid && cfg_ready)
            limit_reg <= stem_limit;
    end

    // Front end: sequence collection, separator folding and limit checks.
    ufs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .limit        (limit_reg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .byte_present (byte_present),
        .title_end    (title_end),
        .q_full       (q_full),
        .push         (push),
        .job          (push_job)
    );

    // Jobs waiting for the output stage.
    ufs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wdata     (push_job),
        .full      (q_full),
        .pop       (pop),
        .rdata     (head_job),
        .not_empty (head_valid)
    );

    // Output stage: one stem byte per cycle while out_stall is low.
    ufs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_job),
        .head_valid  (head_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .out_present (out_present),
        .stem_end    (stem_end)
    );

endmodule

`default_nettype wire
